### sv/imufp_pkg.sv
// imufp_pkg: shared constants and types for the IMU frame parser.
// No dependencies; used by every module of the block.
`default_nettype none

package imufp_pkg;

  localparam logic [7:0] HDR_BYTE  = 8'h5A;
  localparam logic [7:0] TYPE_RATE = 8'hAA;
  localparam logic [7:0] TYPE_YAW  = 8'hBB;

  localparam int RAW_W    = 16;
  localparam int SCALED_W = 20;
  localparam int TDATA_W  = 40;  // raw + scaled (36 bits) padded to bytes

  // Position within a frame: bytes taken so far
  localparam logic [2:0] POS_HDR  = 3'd0;
  localparam logic [2:0] POS_TYPE = 3'd1;
  localparam logic [2:0] POS_LOW  = 3'd2;
  localparam logic [2:0] POS_HIGH = 3'd3;
  localparam logic [2:0] POS_SUM  = 3'd4;

  localparam logic KIND_RATE = 1'b0;
  localparam logic KIND_YAW  = 1'b1;

  typedef struct packed {
    logic                    ok;    // good frame completes on this byte
    logic                    kind;  // KIND_RATE or KIND_YAW
    logic signed [RAW_W-1:0] raw;
  } frame_t;

endpackage

`default_nettype wire

### sv/imufp_framer.sv
// imufp_framer: byte counter and frame byte stores; flags a good frame
// on the checksum byte. Depends on imufp_pkg.
`default_nettype none

module imufp_framer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            byte_vld,
  input  wire logic [7:0]      byte_data,
  output imufp_pkg::frame_t    frame
);

  logic [2:0] count_r, count_nxt;
  logic [7:0] type_r;
  logic [7:0] low_r;
  logic [7:0] high_r;
  logic [7:0] sum;
  logic       type_known;

  always_comb begin
    count_nxt = count_r;
    if (byte_vld) begin
      unique case (count_r)
        imufp_pkg::POS_HDR:  count_nxt = (byte_data == imufp_pkg::HDR_BYTE)
                                         ? imufp_pkg::POS_TYPE : imufp_pkg::POS_HDR;
        imufp_pkg::POS_TYPE: count_nxt = imufp_pkg::POS_LOW;
        imufp_pkg::POS_LOW:  count_nxt = imufp_pkg::POS_HIGH;
        imufp_pkg::POS_HIGH: count_nxt = imufp_pkg::POS_SUM;
        default:             count_nxt = imufp_pkg::POS_HDR;  // checksum byte ends the frame
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= imufp_pkg::POS_HDR;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Byte stores need no reset: each is written before the checksum reads it
  always_ff @(posedge clk) begin
    if (byte_vld && count_r == imufp_pkg::POS_TYPE) begin
      type_r <= byte_data;
    end
    if (byte_vld && count_r == imufp_pkg::POS_LOW) begin
      low_r <= byte_data;
    end
    if (byte_vld && count_r == imufp_pkg::POS_HIGH) begin
      high_r <= byte_data;
    end
  end

  assign sum        = imufp_pkg::HDR_BYTE + type_r + low_r + high_r;
  assign type_known = (type_r == imufp_pkg::TYPE_RATE) || (type_r == imufp_pkg::TYPE_YAW);

  always_comb begin
    frame.ok   = byte_vld && (count_r > imufp_pkg::POS_HIGH) && type_known
                 && (sum == byte_data);
    frame.kind = (type_r == imufp_pkg::TYPE_YAW) ? imufp_pkg::KIND_YAW
                                                 : imufp_pkg::KIND_RATE;
    frame.raw  = {high_r, low_r};
  end

endmodule

`default_nettype wire

### sv/imufp_scaler.sv
// imufp_scaler: converts the raw sensor word to fixed point with 8
// fraction bits, rounded toward negative infinity. Depends on imufp_pkg.
`default_nettype none

module imufp_scaler (
  input  wire logic                                  kind,
  input  wire logic signed [imufp_pkg::RAW_W-1:0]    raw,
  output logic signed [imufp_pkg::SCALED_W-1:0]      scaled
);

  // rate: raw*2000/32768*256 = raw*125/8 ; yaw: raw*180/32768*256 = raw*45/32
  logic signed [22:0] rate_prod;
  logic signed [22:0] rate_shr;
  logic signed [21:0] yaw_prod;
  logic signed [21:0] yaw_shr;

  assign rate_prod = 23'(raw) * 23'sd125;
  assign rate_shr  = rate_prod >>> 3;  // arithmetic shift floors
  assign yaw_prod  = 22'(raw) * 22'sd45;
  assign yaw_shr   = yaw_prod >>> 5;

  always_comb begin
    unique case (kind)
      imufp_pkg::KIND_YAW: scaled = yaw_shr[imufp_pkg::SCALED_W-1:0];
      default:             scaled = rate_shr[imufp_pkg::SCALED_W-1:0];
    endcase
  end

endmodule

`default_nettype wire

### sv/imu_frame_parser.sv
// imu_frame_parser: top level; byte stream in, scaled rate/yaw results out.
// Depends on imufp_pkg, imufp_framer and imufp_scaler.
//
//   channel | ports           | payload
//   --------+-----------------+-----------------------------------------------
//   input   | in_tvalid/tready| tdata[7:0] rx_byte
//   result  | out_tvalid/ready| tdata[15:0] raw_value, [35:16] scaled_value;
//           |                 | tuser value_kind
//
// Cycles: one byte is taken per cycle while in_tready is high; a result
// appears in the cycle after the checksum byte of a good frame is taken.
// The path from stored frame bytes through one constant multiply into the
// result register sets the timing; everything else is a byte compare.
// Stalls: the result register holds until taken; input is accepted while the
// register is empty or being drained in the same cycle.
// Reset: synchronous, active low; clears the byte counter and result valid.
`default_nettype none

module imu_frame_parser (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,   // [7:0] rx_byte
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [imufp_pkg::TDATA_W-1:0]        out_tdata,  // [15:0] raw_value,
                                                           // [35:16] scaled_value
  output logic                                 out_tuser   // value_kind
);

  imufp_pkg::frame_t frame;

  logic                                   in_xfer;
  logic                                   out_valid_r, out_valid_nxt;
  logic                                   out_kind_r;
  logic signed [imufp_pkg::RAW_W-1:0]     out_raw_r;
  logic signed [imufp_pkg::SCALED_W-1:0]  out_scaled_r;
  logic signed [imufp_pkg::SCALED_W-1:0]  scaled;

  // Accept while the result register is free or emptied this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  imufp_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (in_xfer),
    .byte_data (in_tdata),
    .frame     (frame)
  );

  imufp_scaler u_scaler (
    .kind   (frame.kind),
    .raw    (frame.raw),
    .scaled (scaled)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (frame.ok) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load payload only on a good frame; hold otherwise
  always_ff @(posedge clk) begin
    if (frame.ok) begin
      out_kind_r   <= frame.kind;
      out_raw_r    <= frame.raw;
      out_scaled_r <= scaled;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {4'b0000, out_scaled_r, out_raw_r};

endmodule

`default_nettype wire

### sv/imufp_checker.sv
// imufp_checker: port-level assertions for imu_frame_parser, bound to it.
// Depends on imufp_pkg for widths.
`default_nettype none

module imufp_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [imufp_pkg::TDATA_W-1:0] out_tdata,
  input wire logic                          out_tuser
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A fresh result only follows an input transfer
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result without input transfer");

  // Floor scaling keeps the sign of the raw word
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[35] == out_tdata[15])
    else $error("scaled sign differs from raw sign");

  // Padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:36] == 4'b0000)
    else $error("tdata padding not zero");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind imu_frame_parser imufp_checker u_imufp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

### tb/imu_frame_parser_test.sv
// imu_frame_parser_test: self-checking testbench for the IMU frame parser.
// Depends on imufp_pkg and imu_frame_parser; drives bytes, checks each reading.

module imu_frame_parser_test;

  typedef struct {
    logic                                  kind;
    logic signed [imufp_pkg::RAW_W-1:0]    raw;
    logic signed [imufp_pkg::SCALED_W-1:0] scaled;
  } reading_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [7:0]                    in_tdata = 8'h00;   // [7:0] rx_byte
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [imufp_pkg::TDATA_W-1:0] out_tdata;  // [15:0] raw_value, [35:16] scaled_value
  logic                          out_tuser;  // value_kind

  // Parser state mirrored on the sender side
  logic [2:0] model_count = imufp_pkg::POS_HDR;
  logic [7:0] model_type;
  logic [7:0] model_low;
  logic [7:0] model_high;

  reading_t   pending_readings[$];
  int         error_count = 0;
  int         bytes_parsed = 0;
  bit         steady = 1'b0;              // suppress idling on both sides

  imu_frame_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Generous ceiling on the whole run
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  // Idle roughly one cycle in five unless a steady stretch is running
  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 20);
  endfunction

  // Advance the mirrored parser by one transferred byte; queue any reading.
  task automatic track_byte(input logic [7:0] b);
    logic [7:0]        sum;
    logic signed [15:0] raw;
    longint            prod;
    reading_t          rd;
    bytes_parsed++;
    unique case (model_count)
      imufp_pkg::POS_HDR: begin
        if (b == imufp_pkg::HDR_BYTE) model_count = imufp_pkg::POS_TYPE;
      end
      imufp_pkg::POS_TYPE: begin
        model_type = b;
        model_count = imufp_pkg::POS_LOW;
      end
      imufp_pkg::POS_LOW: begin
        model_low = b;
        model_count = imufp_pkg::POS_HIGH;
      end
      imufp_pkg::POS_HIGH: begin
        model_high = b;
        model_count = imufp_pkg::POS_SUM;
      end
      default: begin
        // checksum byte; anything past four acts the same
        model_count = imufp_pkg::POS_HDR;
        sum = imufp_pkg::HDR_BYTE + model_type + model_low + model_high;
        if ((model_type == imufp_pkg::TYPE_RATE || model_type == imufp_pkg::TYPE_YAW)
            && sum == b) begin
          raw = {model_high, model_low};
          prod = raw;
          // floor division: arithmetic shift of the signed product
          if (model_type == imufp_pkg::TYPE_RATE) begin
            prod = (prod * 125) >>> 3;
            rd.kind = imufp_pkg::KIND_RATE;
          end else begin
            prod = (prod * 45) >>> 5;
            rd.kind = imufp_pkg::KIND_YAW;
          end
          rd.raw = raw;
          rd.scaled = prod[imufp_pkg::SCALED_W-1:0];
          pending_readings.push_back(rd);
        end
      end
    endcase
  endtask

  // Move one byte across the input channel, idling at random first.
  task automatic send_byte(input logic [7:0] b);
    while (take_break()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    track_byte(b);
  endtask

  // Send a whole frame; a nonzero skew corrupts the checksum.
  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] raw,
                            input logic [7:0] skew);
    logic [7:0] sum;
    sum = imufp_pkg::HDR_BYTE + ftype + raw[7:0] + raw[15:8];
    send_byte(imufp_pkg::HDR_BYTE);
    send_byte(ftype);
    send_byte(raw[7:0]);
    send_byte(raw[15:8]);
    send_byte(sum + skew);
  endtask

  // Hold the sender off until every queued reading has been taken.
  task automatic drain_readings();
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Report one mismatch and count it
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
    error_count++;
  endtask

  // Result side: check each transfer against the oldest reading, then pick
  // the next cycle's ready.
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected transfer, raw",
                        $signed(out_tdata[imufp_pkg::RAW_W-1:0]), 0);
      end else begin
        want = pending_readings.pop_front();
        if (out_tuser !== want.kind)
          report_mismatch("value_kind", out_tuser, want.kind);
        if (out_tdata[imufp_pkg::RAW_W-1:0] !== want.raw)
          report_mismatch("raw_value", $signed(out_tdata[imufp_pkg::RAW_W-1:0]), want.raw);
        if (out_tdata[imufp_pkg::RAW_W +: imufp_pkg::SCALED_W] !== want.scaled)
          report_mismatch("scaled_value",
                          $signed(out_tdata[imufp_pkg::RAW_W +: imufp_pkg::SCALED_W]),
                          want.scaled);
      end
    end
    out_tready <= !take_break();
  end

  // Drop noise while hunting, then a header inside a frame body.
  task automatic test_hunting();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(imufp_pkg::TYPE_YAW, 16'h5A5A, 8'h00);
  endtask

  // Largest and smallest raw values for rate frames; smallest and -1 for yaw.
  task automatic test_extremes();
    send_frame(imufp_pkg::TYPE_RATE, 16'h7FFF, 8'h00);
    send_frame(imufp_pkg::TYPE_RATE, 16'h8000, 8'h00);
    send_frame(imufp_pkg::TYPE_YAW, 16'h8000, 8'h00);
    send_frame(imufp_pkg::TYPE_YAW, 16'hFFFF, 8'h00);
  endtask

  // Bad checksum, then an unknown type that carries a good checksum.
  task automatic test_rejected_frames();
    send_frame(imufp_pkg::TYPE_RATE, 16'h1234, 8'h01);
    send_frame(8'h00, 16'h0100, 8'h00);
  endtask

  // Back-to-back frames with no idling, then pause until all have come out.
  task automatic test_drain();
    steady = 1'b1;
    send_frame(imufp_pkg::TYPE_RATE, 16'h0001, 8'h00);
    send_frame(imufp_pkg::TYPE_YAW, 16'hFFFE, 8'h00);
    send_frame(imufp_pkg::TYPE_RATE, 16'h0000, 8'h00);
    drain_readings();
    steady = 1'b0;
  endtask

  // Mostly good frames with random content, plus noise and broken frames.
  task automatic test_random_stream();
    int         pick;
    int         n;
    logic [7:0] ftype;
    logic [15:0] raw;
    while (bytes_parsed < 1900) begin
      // one long stretch with no idling on either side
      steady = (bytes_parsed > 800 && bytes_parsed < 1100);
      pick = $urandom_range(99);
      raw = $urandom_range(15) == 0 ? ($urandom_range(1) ? 16'h7FFF : 16'h8000)
                                    : 16'($urandom_range(65535));
      if (pick < 65) begin
        send_frame($urandom_range(1) ? imufp_pkg::TYPE_RATE : imufp_pkg::TYPE_YAW,
                   raw, 8'h00);
      end else if (pick < 75) begin
        send_frame($urandom_range(1) ? imufp_pkg::TYPE_RATE : imufp_pkg::TYPE_YAW, raw,
                   8'($urandom_range(1, 255)));
      end else if (pick < 82) begin
        do ftype = 8'($urandom_range(255));
        while (ftype == imufp_pkg::TYPE_RATE || ftype == imufp_pkg::TYPE_YAW);
        send_frame(ftype, raw, $urandom_range(1) ? 8'h00 : 8'($urandom_range(255)));
      end else if (pick < 92) begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte($urandom_range(7) == 0 ? imufp_pkg::HDR_BYTE
                                                     : 8'($urandom_range(255)));
      end else begin
        // cut-off frame: the stream realigns on later bytes
        send_byte(imufp_pkg::HDR_BYTE);
        n = $urandom_range(1, 3);
        repeat (n) send_byte(8'($urandom_range(255)));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_hunting();
    test_extremes();
    test_rejected_frames();
    test_drain();
    test_random_stream();
    drain_readings();
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
sv/imufp_pkg.sv
sv/imufp_framer.sv
sv/imufp_scaler.sv
sv/imu_frame_parser.sv
sv/imufp_checker.sv
tb/imu_frame_parser_test.sv
